[hw/rtl/ckl_pkg.sv]
// Shared types, widths and codes for the compacting key list.
package ckl_pkg;

  localparam int unsigned DEPTH     = 8;
  localparam int unsigned KEY_BITS  = 64;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned ECNT_W    = 4;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TDATA_IN  = KEY_W;
  localparam int unsigned TDATA_OUT = POS_W + KEY_W + ECNT_W;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LIST   = 2'd2;

  localparam logic [STATUS_W-1:0] STS_INSERTED   = 3'd0;
  localparam logic [STATUS_W-1:0] STS_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] STS_REMOVED    = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_EMPTY_RM   = 3'd4;
  localparam logic [STATUS_W-1:0] STS_LISTED     = 3'd5;
  localparam logic [STATUS_W-1:0] STS_LIST_EMPTY = 3'd6;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_ROTATE
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_e;

  // per-cell control
  typedef struct packed {
    logic load;
    logic take;
    logic live;
  } cell_ctl_t;

  // request from the sequencer to the cell row
  typedef struct packed {
    cmd_e               cmd;
    logic [CNT_W-1:0]   count;
    logic [KEY_BITS-1:0] key;
  } chain_req_t;

  // answer from the cell row
  typedef struct packed {
    logic               found;
    logic [CNT_W-1:0]   pos;
    logic [KEY_BITS-1:0] head;
  } chain_rsp_t;

endpackage

[hw/rtl/ckl_cell.sv]
// One list cell: holds a key, compares it and takes its neighbor's key on a shift.
module ckl_cell
  import ckl_pkg::*;
(
  input  logic                clk_i,
  input  cell_ctl_t           ctl_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [KEY_BITS-1:0] next_key_i,
  input  logic                seen_i,
  output logic                seen_o,
  output logic                hit_o,
  output logic [KEY_BITS-1:0] key_o
);

  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] key_d;
  logic                match;

  assign match  = ctl_i.live && (key_q == key_i);
  assign hit_o  = match && !seen_i;
  assign seen_o = seen_i || match;
  assign key_o  = key_q;

  always_comb begin
    key_d = key_q;
    if (ctl_i.load) begin
      key_d = key_i;
    end else if (ctl_i.take) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

[hw/rtl/ckl_chain.sv]
// Row of list cells with the first-match ripple and shift/rotate steering.
module ckl_chain
  import ckl_pkg::*;
(
  input  logic       clk_i,
  input  chain_req_t req_i,
  output chain_rsp_t rsp_o
);

  logic [KEY_BITS-1:0] keys [DEPTH];
  logic [KEY_BITS-1:0] nxt  [DEPTH];
  logic [DEPTH:0]      seen;
  logic [DEPTH-1:0]    hit;
  cell_ctl_t           ctl  [DEPTH];

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic live;
    logic tail;

    assign live = CNT_W'(i) < req_i.count;
    assign tail = CNT_W'(i + 1) == req_i.count;

    // wrap the live part of the row back onto the head when rotating
    if (i == DEPTH - 1) begin : g_end
      assign nxt[i] = keys[0];
    end else begin : g_mid
      assign nxt[i] = tail ? keys[0] : keys[i + 1];
    end

    always_comb begin
      ctl[i].live = live;
      ctl[i].load = (req_i.cmd == CMD_INSERT) && (CNT_W'(i) == req_i.count);
      case (req_i.cmd)
        CMD_REMOVE: ctl[i].take = live && seen[i + 1];
        CMD_ROTATE: ctl[i].take = live;
        default:    ctl[i].take = 1'b0;
      endcase
    end

    ckl_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl[i]),
      .key_i      (req_i.key),
      .next_key_i (nxt[i]),
      .seen_i     (seen[i]),
      .seen_o     (seen[i + 1]),
      .hit_o      (hit[i]),
      .key_o      (keys[i])
    );
  end

  // at most one hit: OR the one-based positions together
  always_comb begin
    rsp_o.pos = '0;
    for (int unsigned k = 0; k < DEPTH; k++) begin
      if (hit[k]) begin
        rsp_o.pos = rsp_o.pos | CNT_W'(k + 1);
      end
    end
  end

  assign rsp_o.found = seen[DEPTH];
  assign rsp_o.head  = keys[0];

endmodule

[hw/rtl/compacting_key_list_top.sv]
// Compacting key list top level: item sequencer, output register and cell row.
// Insert, remove and an empty list load their one result from the execute state that follows
// acceptance; compare and compaction shift run across the cell row in that same cycle.
// A non-empty list then loads results in the list state, one per cycle while the output
// register is free, as the row rotates; the unused action gives none, and a full output
// register stalls the sequencer. rst_ni clears count, state and valid.
module compacting_key_list_top
  import ckl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TDATA_IN-1:0]  s_axis_tdata,   // [63:0] key
  input  logic [ACT_W-1:0]     s_axis_tuser,   // [1:0] action
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TDATA_OUT-1:0] m_axis_tdata,   // [3:0] position, [67:4] key_out,
                                               // [71:68] entry_count
  output logic [STATUS_W-1:0]  m_axis_tuser,   // [2:0] status
  output logic                 m_axis_tlast
);

  state_e state_q, state_d;

  // accepted item
  logic [ACT_W-1:0] act_q;
  logic [KEY_W-1:0] key_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [POS_W-1:0]    out_pos_q, out_pos_d;
  logic [KEY_W-1:0]    out_key_q, out_key_d;
  logic [ECNT_W-1:0]   out_cnt_q, out_cnt_d;
  logic                out_last_q, out_last_d;
  logic                out_load;
  logic                out_free;

  chain_req_t req;
  chain_rsp_t rsp;
  logic       accept;
  logic       list_last;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign list_last     = (CNT_W'(idx_q) + 1'b1) == count_q;

  ckl_chain u_chain (
    .clk_i (clk_i),
    .req_i (req),
    .rsp_o (rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (act_q == ACT_LIST) begin
          if (count_q != '0) begin
            state_d = S_LIST;
          end else if (out_free) begin
            state_d = S_IDLE;
          end
        end else if (act_q == ACT_INSERT || act_q == ACT_REMOVE) begin
          if (out_free) begin
            state_d = S_IDLE;
          end
        end else begin
          // unused action: drop silently
          state_d = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free && list_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer: row command, count, list index and result fields
  always_comb begin
    req.cmd      = CMD_NONE;
    req.count    = count_q;
    req.key      = key_q[KEY_BITS-1:0];
    count_d      = count_q;
    idx_d        = idx_q;
    out_load     = 1'b0;
    out_status_d = STS_INSERTED;
    out_pos_d    = '0;
    out_key_d    = '0;
    out_last_d   = 1'b1;
    case (state_q)
      S_EXEC: begin
        idx_d = '0;
        if (out_free) begin
          if (act_q == ACT_INSERT) begin
            out_load = 1'b1;
            if (count_q < CNT_W'(DEPTH)) begin
              req.cmd      = CMD_INSERT;
              count_d      = count_q + 1'b1;
              out_status_d = STS_INSERTED;
            end else begin
              out_status_d = STS_FULL;
            end
          end else if (act_q == ACT_REMOVE) begin
            out_load = 1'b1;
            if (count_q == '0) begin
              out_status_d = STS_EMPTY_RM;
            end else begin
              req.cmd = CMD_REMOVE;
              if (rsp.found) begin
                count_d      = count_q - 1'b1;
                out_status_d = STS_REMOVED;
                out_pos_d    = POS_W'(rsp.pos);
              end else begin
                out_status_d = STS_NOT_FOUND;
              end
            end
          end else if (act_q == ACT_LIST && count_q == '0) begin
            out_load     = 1'b1;
            out_status_d = STS_LIST_EMPTY;
          end
        end
      end
      S_LIST: begin
        if (out_free) begin
          // emit the head and rotate the live entries one place
          req.cmd      = CMD_ROTATE;
          out_load     = 1'b1;
          out_status_d = STS_LISTED;
          out_pos_d    = POS_W'(CNT_W'(idx_q) + 1'b1);
          out_key_d    = KEY_W'(rsp.head);
          out_last_d   = list_last;
          idx_d        = idx_q + 1'b1;
        end
      end
      default: begin
        req.cmd = CMD_NONE;
      end
    endcase
    out_cnt_d   = ECNT_W'(count_d);
    out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload: hold the accepted item and the pending result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= s_axis_tuser;
      key_q <= s_axis_tdata;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_pos_q    <= out_pos_d;
      out_key_q    <= out_key_d;
      out_cnt_q    <= out_cnt_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_cnt_q, out_key_q, out_pos_q};
  assign m_axis_tlast  = out_last_q;

endmodule

[dv/compacting_key_list_top_test.sv]
// Self-checking testbench for the compacting key list top level.
module compacting_key_list_top_test;
  import ckl_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MASK   = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
  localparam logic [KEY_W-1:0] ALL_ONES   = {KEY_W{1'b1}};

  localparam int unsigned RAND_PER_PHASE = 120;   // counted items per idling phase
  localparam int unsigned STALL_LIMIT    = 2000;  // cycles with no handshake at all
  localparam int unsigned LONG_HOLD      = 300;   // receiver back-pressure stretch
  localparam int unsigned DRAIN_CYCLES   = 20;    // settle time after the last result

  // One expected output item, unpacked from tdata/tuser/tlast.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    key_out;
    logic [ECNT_W-1:0]   entry_count;
    logic                last;
  } list_result_t;

  // Directed stimulus row; typed rows carry their single expected result.
  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [KEY_W-1:0]    key;
    logic                typed;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [ECNT_W-1:0]   entry_count;
  } stim_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_IN-1:0]  s_axis_tdata  = '0;   // [63:0] key
  logic [ACT_W-1:0]     s_axis_tuser  = '0;   // [1:0] action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_OUT-1:0] m_axis_tdata;         // [3:0] position, [67:4] key_out,
                                              // [71:68] entry_count
  logic [STATUS_W-1:0]  m_axis_tuser;         // [2:0] status
  logic                 m_axis_tlast;

  // Shadow copy of the list, advanced at every accepted input item.
  logic [KEY_W-1:0] shadow_keys [DEPTH];
  int unsigned      shadow_count = 0;

  list_result_t pending_results [$];   // results still owed by the block, oldest first
  list_result_t step_results [$];      // results of the item just predicted

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  bit          rx_hold_req  = 1'b0;
  int unsigned rx_hold_left = 0;
  int unsigned quiet_cycles = 0;
  bit          error_seen   = 1'b0;

  stim_row_t directed_rows [24] = '{
    '{ACT_LIST,   64'h0,                  1'b1, STS_LIST_EMPTY, 4'd0, 4'd0},
    '{ACT_REMOVE, 64'h0,                  1'b1, STS_EMPTY_RM,   4'd0, 4'd0},
    '{ACT_UNUSED, ALL_ONES,               1'b0, STS_INSERTED,   4'd0, 4'd0},
    '{ACT_INSERT, 64'h0,                  1'b1, STS_INSERTED,   4'd0, 4'd1},
    '{ACT_INSERT, ALL_ONES,               1'b1, STS_INSERTED,   4'd0, 4'd2},
    '{ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, STS_INSERTED,  4'd0, 4'd3},
    '{ACT_INSERT, 64'h5555_5555_5555_5555, 1'b1, STS_INSERTED,  4'd0, 4'd4},
    '{ACT_INSERT, ALL_ONES,               1'b1, STS_INSERTED,   4'd0, 4'd5},
    '{ACT_INSERT, 64'h1,                  1'b1, STS_INSERTED,   4'd0, 4'd6},
    '{ACT_INSERT, 64'h8000_0000_0000_0000, 1'b1, STS_INSERTED,  4'd0, 4'd7},
    '{ACT_INSERT, 64'h0123_4567_89AB_CDEF, 1'b1, STS_INSERTED,  4'd0, 4'd8},
    '{ACT_INSERT, 64'hDEAD,               1'b1, STS_FULL,       4'd0, 4'd8},
    '{ACT_LIST,   64'h0,                  1'b0, STS_INSERTED,   4'd0, 4'd0},
    '{ACT_REMOVE, ALL_ONES,               1'b1, STS_REMOVED,    4'd2, 4'd7},
    '{ACT_REMOVE, 64'hDEAD,               1'b1, STS_NOT_FOUND,  4'd0, 4'd7},
    '{ACT_UNUSED, 64'h0,                  1'b0, STS_INSERTED,   4'd0, 4'd0},
    '{ACT_LIST,   ALL_ONES,               1'b0, STS_INSERTED,   4'd0, 4'd0},
    '{ACT_REMOVE, 64'h0123_4567_89AB_CDEF, 1'b1, STS_REMOVED,   4'd7, 4'd6},
    '{ACT_REMOVE, 64'h0,                  1'b1, STS_REMOVED,    4'd1, 4'd5},
    '{ACT_REMOVE, ALL_ONES,               1'b1, STS_REMOVED,    4'd3, 4'd4},
    '{ACT_LIST,   64'h0,                  1'b0, STS_INSERTED,   4'd0, 4'd0},
    '{ACT_REMOVE, 64'h8000_0000_0000_0000, 1'b0, STS_INSERTED,  4'd0, 4'd0},
    '{ACT_INSERT, 64'hDEAD,               1'b0, STS_INSERTED,   4'd0, 4'd0},
    '{ACT_LIST,   64'h0,                  1'b0, STS_INSERTED,   4'd0, 4'd0}
  };

  compacting_key_list_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Append one result, tagged with the entry count after the step.
  function automatic void add_result(input logic [STATUS_W-1:0] status,
                                     input int unsigned position,
                                     input logic [KEY_W-1:0] key_out,
                                     input logic last);
    list_result_t res;
    res.status      = status;
    res.position    = position[POS_W-1:0];
    res.key_out     = key_out;
    res.entry_count = shadow_count[ECNT_W-1:0];
    res.last        = last;
    step_results.push_back(res);
  endfunction

  // Advance the shadow list by one item and collect the results it causes.
  function automatic void predict_list_op(input logic [ACT_W-1:0] action,
                                          input logic [KEY_W-1:0] key_in);
    logic [KEY_W-1:0] key;
    int               hit;
    key = key_in & KEY_MASK;
    hit = -1;
    step_results.delete();
    case (action)
      ACT_INSERT: begin
        if (shadow_count < DEPTH) begin
          shadow_keys[shadow_count] = key;
          shadow_count++;
          add_result(STS_INSERTED, 0, '0, 1'b1);
        end else begin
          add_result(STS_FULL, 0, '0, 1'b1);
        end
      end
      ACT_REMOVE: begin
        if (shadow_count == 0) begin
          add_result(STS_EMPTY_RM, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++)
            if (hit < 0 && shadow_keys[i] == key) hit = i;
          if (hit < 0) begin
            add_result(STS_NOT_FOUND, 0, '0, 1'b1);
          end else begin
            // close the gap: every later entry moves down one place
            for (int j = hit; j + 1 < shadow_count; j++) shadow_keys[j] = shadow_keys[j + 1];
            shadow_count--;
            add_result(STS_REMOVED, hit + 1, '0, 1'b1);
          end
        end
      end
      ACT_LIST: begin
        if (shadow_count == 0) begin
          add_result(STS_LIST_EMPTY, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++)
            add_result(STS_LISTED, i + 1, shadow_keys[i], (i + 1 == shadow_count));
        end
      end
      default: ;  // unused action: no result, no state change
    endcase
  endfunction

  // Offer one item, hold it until accepted, then book its expected results.
  task automatic send_item(input logic [ACT_W-1:0] action, input logic [KEY_W-1:0] key,
                           input logic typed, input list_result_t typed_result);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    predict_list_op(action, key);
    if (typed) pending_results.push_back(typed_result);
    else foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  // Mostly well-formed traffic: removes usually name a stored key, and keys come
  // from a small set often enough to build duplicates.
  task automatic pick_random_item(output logic [ACT_W-1:0] action,
                                  output logic [KEY_W-1:0] key);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) action = ACT_UNUSED;
    else if (r < 44) action = ACT_INSERT;
    else if (r < 74) action = ACT_REMOVE;
    else action = ACT_LIST;
    key = {$urandom, $urandom};
    if (action == ACT_REMOVE && shadow_count != 0 && $urandom_range(99) < 65)
      key = shadow_keys[$urandom_range(shadow_count - 1)];
    else if ($urandom_range(99) < 40)
      key = {{(KEY_W - 4){1'b0}}, 4'($urandom_range(15))};
  endtask

  // Drop valid and hold until the block owes nothing.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = LONG_HOLD;
      rx_hold_req  = 1'b0;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check every accepted result against the oldest expectation; watch for a hang.
  always @(posedge clk_i) begin : result_monitor
    list_result_t want;
    logic         out_hs;
    logic         in_hs;
    out_hs = (rst_ni === 1'b1) && (m_axis_tvalid === 1'b1) && (m_axis_tready === 1'b1);
    in_hs  = (s_axis_tvalid === 1'b1) && (s_axis_tready === 1'b1);
    if (out_hs) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d tdata %h", m_axis_tuser, m_axis_tdata);
        error_seen = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          error_seen = 1'b1;
        end
        if (m_axis_tdata[POS_W-1:0] !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, m_axis_tdata[POS_W-1:0]);
          error_seen = 1'b1;
        end
        if (m_axis_tdata[POS_W +: KEY_W] !== want.key_out) begin
          $error("key_out: expected %h, got %h", want.key_out, m_axis_tdata[POS_W +: KEY_W]);
          error_seen = 1'b1;
        end
        if (m_axis_tdata[POS_W + KEY_W +: ECNT_W] !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 m_axis_tdata[POS_W + KEY_W +: ECNT_W]);
          error_seen = 1'b1;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          error_seen = 1'b1;
        end
      end
    end
    if (out_hs || in_hs) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    list_result_t     typed_res;
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] key;
    int unsigned      sent;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the first idling mix.
    tx_idle_pct = 16;
    rx_idle_pct = 47;
    foreach (directed_rows[r]) begin
      typed_res.status      = directed_rows[r].status;
      typed_res.position    = directed_rows[r].position;
      typed_res.key_out     = '0;
      typed_res.entry_count = directed_rows[r].entry_count;
      typed_res.last        = 1'b1;
      send_item(directed_rows[r].action, directed_rows[r].key, directed_rows[r].typed,
                typed_res);
    end
    wait_drained();

    // Random part: swap the idling mix each phase, end with full throughput.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 16; rx_idle_pct = 47; end
        1: begin tx_idle_pct = 47; rx_idle_pct = 16; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      // long receiver stall while items keep coming: fills the block
      if (phase == 0) rx_hold_req = 1'b1;
      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        pick_random_item(action, key);
        typed_res = '0;
        send_item(action, key, 1'b0, typed_res);
        if (action != ACT_UNUSED) sent++;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!error_seen) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
